// ===== rtl/prld_pkg.sv =====
// ----------------------------------------------------------------------------
// prld_pkg
// Shared types and codes for the palette run-length line decoder.
// ----------------------------------------------------------------------------
package prld_pkg;

	// palette depth default for the top-level parameter
	localparam int unsigned PALETTE_ENTRIES_DEF = 32;

	// configuration register indexes
	localparam logic [2:0] CFG_COLOR_MODE   = 3'd0;
	localparam logic [2:0] CFG_LINE_WIDTH   = 3'd1;
	localparam logic [2:0] CFG_CROP_START   = 3'd2;
	localparam logic [2:0] CFG_CROP_WIDTH   = 3'd3;
	localparam logic [2:0] CFG_PIXEL_FORMAT = 3'd4;

	// input item kinds
	localparam logic ACT_PALETTE = 1'b0;
	localparam logic ACT_DATA    = 1'b1;

	// colour modes and pixel formats
	localparam logic       MODE_NIBBLE = 1'b0;
	localparam logic [1:0] FMT_16BIT   = 2'd0;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TRUNC   = 2'd1;
	localparam logic [1:0] ST_OVERRUN = 2'd2;
	localparam logic [1:0] ST_BADCOL  = 2'd3;

	// input beat
	typedef struct packed {
		logic       action;
		logic [4:0] palette_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] data_byte;
		logic       end_of_data;
	} prld_in_t;

	// output beat
	typedef struct packed {
		logic [23:0] pixel_value;
		logic [15:0] run_count;
		logic        end_of_line;
		logic [1:0]  status;
	} prld_out_t;

	// run descriptor from the parser, before the palette lookup
	typedef struct packed {
		logic        emit;
		logic        color_ok;
		logic [7:0]  color;
		logic [15:0] count;
		logic        eol;
		logic [1:0]  status;
	} prld_run_t;

endpackage

// ===== rtl/prld_parse.sv =====
// ----------------------------------------------------------------------------
// prld_parse
// Run header / length parser with column tracking and window clipping.
// ----------------------------------------------------------------------------
module prld_parse import prld_pkg::*; #(
	parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic        end_of_data,
	input  logic        color_mode,
	input  logic [15:0] line_width,
	input  logic [15:0] crop_start,
	input  logic [15:0] crop_width,
	output prld_run_t   run
);

	// parse phases
	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_LOW    = 2'd1;
	localparam logic [1:0] PH_HIGH   = 2'd2;
	localparam logic [1:0] PH_LEN    = 2'd3;

	localparam logic [8:0] ENTRIES = 9'(PALETTE_ENTRIES);

	logic [1:0]  phase_q, phase_d;
	logic [7:0]  color_q, color_d;
	logic [15:0] count_q, count_d;
	logic [16:0] column_q;

	logic        done;
	logic [15:0] cnt;
	logic [17:0] run_end, win_end, lo, hi;
	logic [16:0] newcol;
	logic        eol;
	logic        color_ok;
	logic [1:0]  status;

	// byte decode by phase
	always_comb begin
		phase_d = phase_q;
		color_d = color_q;
		count_d = count_q;
		cnt     = '0;
		done    = 1'b0;
		unique case (phase_q)
			PH_HEADER: begin
				if (color_mode == MODE_NIBBLE) begin
					color_d = {4'd0, data_byte[7:4]};
					if (data_byte[3:0] == 4'd0) begin
						phase_d = PH_HIGH;
					end else if (data_byte[3]) begin
						count_d = {5'd0, data_byte[2:0], 8'd0};
						phase_d = PH_LOW;
					end else begin
						cnt  = {12'd0, data_byte[3:0]};
						done = 1'b1;
					end
				end else begin
					color_d = data_byte;
					phase_d = PH_LEN;
				end
			end
			PH_LOW: begin
				cnt  = count_q + {8'd0, data_byte};
				done = 1'b1;
			end
			PH_HIGH: begin
				count_d = {data_byte, 8'd0};
				phase_d = PH_LOW;
			end
			PH_LEN: begin
				if (data_byte[7]) begin
					count_d = {1'b0, data_byte[6:0], 8'd0};
					phase_d = PH_LOW;
				end else begin
					cnt  = {8'd0, data_byte};
					done = 1'b1;
				end
			end
		endcase
	end

	// clip the run to the window and classify it
	always_comb begin
		run_end  = {1'b0, column_q} + {2'd0, cnt};
		win_end  = {2'd0, crop_start} + {2'd0, crop_width};
		lo       = ({1'b0, column_q} > {2'd0, crop_start}) ? {1'b0, column_q}
		                                                   : {2'd0, crop_start};
		hi       = (run_end < win_end) ? run_end : win_end;
		newcol   = run_end[16:0];
		eol      = newcol >= {1'b0, line_width};
		color_ok = {1'b0, color_d} < ENTRIES;
		if (newcol > {1'b0, line_width})
			status = ST_OVERRUN;
		else if (!color_ok)
			status = ST_BADCOL;
		else if (end_of_data && !eol)
			status = ST_TRUNC;
		else
			status = ST_OK;

		run.emit     = done || end_of_data;
		run.color_ok = done && color_ok;
		run.color    = color_d;
		run.count    = (done && hi > lo) ? 16'(hi - lo) : 16'd0;
		run.eol      = done && eol;
		run.status   = done ? status : ST_TRUNC;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			color_q  <= '0;
			count_q  <= '0;
			column_q <= '0;
		end else if (step) begin
			color_q <= color_d;
			if (done) begin
				phase_q <= PH_HEADER;
				count_q <= count_d;
				if (eol || end_of_data) begin
					column_q <= '0;
					count_q  <= '0;
				end else begin
					column_q <= newcol;
				end
			end else if (end_of_data) begin
				phase_q  <= PH_HEADER;
				column_q <= '0;
				count_q  <= '0;
			end else begin
				phase_q <= phase_d;
				count_q <= count_d;
			end
		end
	end

endmodule

// ===== rtl/prld_palette.sv =====
// ----------------------------------------------------------------------------
// prld_palette
// Palette store: RGB to short/full conversion on write, registered read.
// ----------------------------------------------------------------------------
module prld_palette import prld_pkg::*; #(
	parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        wr_en,
	input  logic [4:0]  wr_index,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic        rd_en,
	input  logic [7:0]  rd_color,
	output logic [15:0] rd_short,
	output logic [23:0] rd_full
);

	localparam int unsigned AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam logic [8:0]  ENTRIES = 9'(PALETTE_ENTRIES);

	logic [15:0] mem_short [PALETTE_ENTRIES];
	logic [23:0] mem_full  [PALETTE_ENTRIES];

	logic [7:0]    wr_index_x;
	logic [AW-1:0] wr_addr, rd_addr;
	logic          wr_ok;
	logic [11:0]   r15, b15;
	logic [12:0]   g31;
	logic [3:0]    r_s, b_s;
	logic [4:0]    g_s;
	logic [15:0]   short_w;

	// floor(x / 255) for x below 65535
	function automatic logic [15:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
		return {7'd0, t[16:8]};
	endfunction

	// x * 15 as shift and subtract
	function automatic logic [11:0] r15_pad(input logic [7:0] v);
		return ({4'd0, v} << 4) - {4'd0, v};
	endfunction

	// scale to 4/5/4 bits, red and blue at half scale
	always_comb begin
		r15     = r15_pad(red);
		g31     = ({5'd0, green} << 5) - {5'd0, green};
		b15     = r15_pad(blue);
		r_s     = 4'(div255({4'd0, r15}));
		g_s     = 5'(div255({3'd0, g31}));
		b_s     = 4'(div255({4'd0, b15}));
		short_w = {1'b0, r_s, 1'b0, g_s, 1'b0, b_s};
	end

	always_comb begin
		wr_index_x = {3'd0, wr_index};
		wr_addr    = wr_index_x[AW-1:0];
		rd_addr    = rd_color[AW-1:0];
		wr_ok      = {1'b0, wr_index_x} < ENTRIES;
	end

	// storage, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en && wr_ok) begin
			mem_short[wr_addr] <= short_w;
			mem_full[wr_addr]  <= {red, green, blue};
		end
		if (rd_en) begin
			rd_short <= mem_short[rd_addr];
			rd_full  <= mem_full[rd_addr];
		end
	end

endmodule

// ===== rtl/palette_rle_line_decoder.sv =====
// ----------------------------------------------------------------------------
// palette_rle_line_decoder
// Palette run-length line decoder, top level.
// ----------------------------------------------------------------------------
// Takes one input beat per clock: either a palette write or one byte of the
// compressed line stream. Each byte that completes a run (or ends the data
// early) gives one output beat in the cycle after it is accepted, via the
// registered palette read. A one-deep output register sits between the
// channels, so input is taken every cycle unless a result is waiting and the
// output is stalled. Write configuration via cfg_we/cfg_index/cfg_data only
// while the block is idle (not enforced by it); unused indexes are ignored.
module palette_rle_line_decoder import prld_pkg::*; #(
	parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  prld_in_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output prld_out_t   out_data
);

	logic        color_mode_q;
	logic [15:0] line_width_q, crop_start_q, crop_width_q;
	logic [1:0]  pixel_format_q;

	logic        accept, data_step, pal_write;
	prld_run_t   run;
	logic [15:0] rd_short;
	logic [23:0] rd_full;

	logic        valid_q, pix_ok_q, fmt_short_q, eol_q;
	logic [15:0] count_q;
	logic [1:0]  status_q;

	assign in_stall  = valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign data_step = accept && (in_data.action == ACT_DATA);
	assign pal_write = accept && (in_data.action == ACT_PALETTE);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q   <= MODE_NIBBLE;
			line_width_q   <= 16'd1;
			crop_start_q   <= '0;
			crop_width_q   <= '0;
			pixel_format_q <= FMT_16BIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COLOR_MODE:   color_mode_q   <= cfg_data[0];
				CFG_LINE_WIDTH:   line_width_q   <= cfg_data;
				CFG_CROP_START:   crop_start_q   <= cfg_data;
				CFG_CROP_WIDTH:   crop_width_q   <= cfg_data;
				CFG_PIXEL_FORMAT: pixel_format_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	prld_parse #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (data_step),
		.data_byte  (in_data.data_byte),
		.end_of_data(in_data.end_of_data),
		.color_mode (color_mode_q),
		.line_width (line_width_q),
		.crop_start (crop_start_q),
		.crop_width (crop_width_q),
		.run        (run)
	);

	prld_palette #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_palette (
		.clk     (clk),
		.wr_en   (pal_write),
		.wr_index(in_data.palette_index),
		.red     (in_data.red),
		.green   (in_data.green),
		.blue    (in_data.blue),
		.rd_en   (data_step && run.color_ok),
		.rd_color(run.color),
		.rd_short(rd_short),
		.rd_full (rd_full)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= data_step && run.emit;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (data_step) begin
			pix_ok_q    <= run.color_ok;
			fmt_short_q <= pixel_format_q == FMT_16BIT;
			count_q     <= run.count;
			eol_q       <= run.eol;
			status_q    <= run.status;
		end
	end

	// pixel form select after the palette read
	always_comb begin
		out_valid            = valid_q;
		out_data.pixel_value = !pix_ok_q   ? 24'd0 :
		                       fmt_short_q ? {8'd0, rd_short} : rd_full;
		out_data.run_count   = count_q;
		out_data.end_of_line = eol_q;
		out_data.status      = status_q;
	end

endmodule

// ===== rtl/prld_checker.sv =====
// ----------------------------------------------------------------------------
// prld_props
// Port-level checks on the decoder's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module prld_props import prld_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input prld_out_t out_data
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// a new result follows an accepted input beat
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall))
		else $error("result without accepted input");

	// overrun always ends the line
	a_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_OVERRUN |-> out_data.end_of_line)
		else $error("overrun without end of line");

	// a line end is never reported as truncated
	a_eol: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.end_of_line |-> out_data.status != ST_TRUNC)
		else $error("truncated status on line end");

	// bad colour gives a zero pixel
	a_badcol: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_BADCOL |-> out_data.pixel_value == 24'd0)
		else $error("bad colour with nonzero pixel");

endmodule

bind palette_rle_line_decoder prld_props u_prld_props (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);
